>>> hdl/windowed_semblance_with_weighting_core_assert.svh
// Assertion macros for the windowed semblance core.
// Included by the top level; no other dependencies.
`ifndef WINDOWED_SEMBLANCE_WITH_WEIGHTING_CORE_ASSERT_SVH
`define WINDOWED_SEMBLANCE_WITH_WEIGHTING_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WSW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wsw assertion failed");
`define WSW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wsw assertion failed");
`else
`define WSW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WSW_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> hdl/wsw_pkg.sv
// Shared types and constants of the windowed semblance core.
// No dependencies.
`timescale 1ns / 1ps
package wsw_pkg;
    localparam int SEMB_W  = 17;
    localparam int TC_W    = 5;
    localparam int SC_W    = 8;
    localparam int DW_W    = 6;
    localparam int WL_W    = 6;
    localparam int THR_W   = 18;
    localparam int K_W     = TC_W + SC_W + DW_W;
    localparam int DVD_W   = THR_W + 16;
    localparam int CIDX_W  = 3;
    localparam logic [SEMB_W-1:0] Q_ONE = 17'h10000;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TRACE_COUNT  = 3'd0,
        CFG_SCATTER      = 3'd1,
        CFG_DIP_WINDOW   = 3'd2,
        CFG_WINDOW_LEN   = 3'd3,
        CFG_WEIGHT_EN    = 3'd4,
        CFG_WEIGHT_LOW   = 3'd5,
        CFG_WEIGHT_HIGH  = 3'd6,
        CFG_UNUSED       = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQUARE, ST_WIN_SETUP, ST_RD, ST_ACC, ST_KMUL1, ST_KMUL2,
        ST_MUL_LO, ST_MUL_HI, ST_CHECK, ST_DIV, ST_WEIGH, ST_OUT
    } state_t;
endpackage

>>> hdl/windowed_semblance_with_weighting_core.sv
// Windowed semblance with threshold weighting: top level and only module.
// Depends on wsw_pkg and windowed_semblance_with_weighting_core_assert.svh.
//
// Input stream s_*: one transaction per trace and depth sample; s_tlast closes the
// depth sample, s_tuser marks that sample as the last of the gather.
// Output stream m_*: one semblance per depth, m_tlast on the last depth of a gather.
// Config channel cfg_*: register index and data, always ready; write only while idle.
// Processing: a transaction without s_tlast only adds into the accumulators. A
// closing transaction takes the square and line write, then per result the
// window sum from the line memory (coh = window_length, 0 taken as 1, at most
// 63; one registered read per entry), the normalizer product and checks, the
// serial quotient, the weighting step and, on the ramp, its division, and the
// load of the output register. The line memory is read one entry at a time.
// No new transaction is taken until the last result is loaded. A gather end
// flushes up to (coh+1)/2 results.
// Reset: synchronous, active low; config registers take defaults; state, input
// sums, depth, slot and m_tvalid clear. The line memory needs no clearing pass.
// Stall: a pending result waits in the output register; the core stalls in its
// output step until that register is free.
`timescale 1ns / 1ps
`include "windowed_semblance_with_weighting_core_assert.svh"
module windowed_semblance_with_weighting_core
    import wsw_pkg::*;
#(
    parameter int MAX_TRACES   = 16,
    parameter int MAX_WINDOW   = 64,
    parameter int MAX_DEPTH    = 4096,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // [SW-1:0] stack_value, [2SW-1:SW] square_value, zero pad above
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,   // last_trace
    input  logic s_tuser,   // last_sample
    output logic m_tvalid,
    input  logic m_tready,
    // [16:0] semblance, then depth_index, zero pad above
    output logic [((SEMB_W+$clog2(MAX_DEPTH)+7)/8)*8-1:0] m_tdata,
    output logic m_tlast,   // last_output
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0] cfg_data
);
    localparam int ACC_W  = SAMPLE_WIDTH + $clog2(MAX_TRACES);
    localparam int SQS_W  = 2 * ACC_W;
    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int NUM_W  = SQS_W + SLOT_W;
    localparam int SQ_W   = ACC_W + SLOT_W;
    localparam int HALF_W = (SQ_W + 1) / 2;
    localparam int DEN_W  = K_W + SQ_W;
    localparam int CMP_W  = (NUM_W > DEN_W) ? NUM_W + 1 : DEN_W + 1;
    localparam int IDX_W  = $clog2(MAX_DEPTH);
    localparam int DEP_W  = IDX_W + 1;
    localparam int CW     = (SLOT_W > WL_W) ? SLOT_W + 1 : WL_W + 1;
    localparam int J_W    = ((DEP_W > CW) ? DEP_W : CW) + 1;
    localparam int OUT_W  = ((SEMB_W + IDX_W + 7) / 8) * 8;
    localparam int MEM_W  = SQS_W + ACC_W;

    // configuration registers
    logic [TC_W-1:0] tc_reg;
    logic [SC_W-1:0] sc_reg;
    logic [DW_W-1:0] dw_reg;
    logic [WL_W-1:0] wl_reg;
    logic wen_reg;
    logic signed [THR_W-1:0] wlo_reg, whi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg <= TC_W'(1);
            sc_reg <= SC_W'(1);
            dw_reg <= DW_W'(11);
            wl_reg <= WL_W'(11);
            wen_reg <= 1'b0;
            wlo_reg <= -THR_W'(65536);
            whi_reg <= -THR_W'(65536);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TRACE_COUNT: tc_reg <= cfg_data[TC_W-1:0];
                CFG_SCATTER:     sc_reg <= cfg_data[SC_W-1:0];
                CFG_DIP_WINDOW:  dw_reg <= cfg_data[DW_W-1:0];
                CFG_WINDOW_LEN:  wl_reg <= cfg_data[WL_W-1:0];
                CFG_WEIGHT_EN:   wen_reg <= cfg_data[0];
                CFG_WEIGHT_LOW:  wlo_reg <= cfg_data;
                CFG_WEIGHT_HIGH: whi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // state and datapath registers
    state_t state_reg, state_next;
    logic [ACC_W-1:0] stk_acc_reg, stk_acc_next, sqr_acc_reg, sqr_acc_next;
    logic [DEP_W-1:0] depth_reg, depth_next, newest_reg, newest_next;
    logic [SLOT_W-1:0] slot_reg, slot_next, nslot_reg, nslot_next;
    logic [SLOT_W-1:0] jslot_reg, jslot_next;
    logic lsamp_reg, lsamp_next, last_reg, last_next;
    logic [CW-1:0] coh_reg, coh_next, cnt_reg, cnt_next;
    logic [DEP_W-1:0] o_reg, o_next, oend_reg, oend_next;
    logic signed [J_W-1:0] j_reg, j_next;
    logic inr_reg, inr_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [SQ_W-1:0] sq_reg, sq_next;
    logic [TC_W+SC_W-1:0] kp_reg, kp_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [DEN_W-1:0] den_reg, den_next, div_reg, div_next;
    logic [CMP_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [SEMB_W-1:0] q_reg, q_next, semb_reg, semb_next;
    logic [5:0] steps_reg, steps_next;
    logic wph_reg, wph_next;
    logic mval_reg, mval_next, mlast_reg, mlast_next;
    logic [OUT_W-1:0] mdata_reg, mdata_next;

    // line memory: squared stack sum and square sum per depth
    logic [MEM_W-1:0] line_mem [MAX_WINDOW];
    logic [MEM_W-1:0] rd_data_reg;
    logic mem_we;
    logic [MEM_W-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) line_mem[slot_reg] <= mem_wdata;
        if (state_reg == ST_RD) rd_data_reg <= line_mem[jslot_reg];
    end

    // combinational helpers
    logic s_acc;
    logic [ACC_W-1:0] mag;
    logic [CW-1:0] wl_eff, coh_eff, h_eff, a_eff, h_cur;
    logic signed [J_W-1:0] first;
    logic signed [J_W-1:0] diff;
    logic signed [SLOT_W:0] js_tmp;
    logic [CMP_W-1:0] rem_sh;
    logic signed [THR_W:0] sv, lo_x, hi_x, ds, vd;
    logic [TC_W-1:0] tc_eff;
    logic [SC_W-1:0] sc_eff;
    logic [DW_W-1:0] dw_eff;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign mag      = stk_acc_reg[ACC_W-1] ? (~stk_acc_reg + ACC_W'(1)) : stk_acc_reg;
    assign mem_we   = (state_reg == ST_SQUARE);
    assign mem_wdata = {sqr_acc_reg, SQS_W'(mag) * SQS_W'(mag)};
    assign tc_eff   = (tc_reg == '0) ? TC_W'(1) : tc_reg;
    assign sc_eff   = (sc_reg == '0) ? SC_W'(1) : sc_reg;
    assign dw_eff   = (dw_reg == '0) ? DW_W'(1) : dw_reg;
    assign wl_eff   = (wl_reg == '0) ? CW'(1) : CW'(wl_reg);
    assign coh_eff  = (wl_eff > CW'(MAX_WINDOW - 1)) ? CW'(MAX_WINDOW - 1) : wl_eff;
    assign h_eff    = coh_eff >> 1;
    assign a_eff    = coh_eff - CW'(1) - h_eff;
    assign first    = $signed(J_W'(depth_reg)) - $signed(J_W'(a_eff));
    assign h_cur    = coh_reg >> 1;
    assign diff     = $signed(J_W'(newest_reg)) - $signed(J_W'(o_reg)) + $signed(J_W'(h_cur));
    assign js_tmp   = $signed({1'b0, nslot_reg}) - $signed({1'b0, diff[SLOT_W-1:0]});
    assign rem_sh   = {rem_reg[CMP_W-2:0], dvd_reg[DVD_W-1]};
    assign sv       = $signed({2'b00, semb_reg});
    assign lo_x     = (THR_W+1)'(wlo_reg);
    assign hi_x     = (THR_W+1)'(whi_reg);
    assign ds       = {whi_reg[THR_W-1], whi_reg} - {wlo_reg[THR_W-1], wlo_reg};
    assign vd       = sv - {wlo_reg[THR_W-1], wlo_reg};

    // state register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            stk_acc_reg <= '0;
            sqr_acc_reg <= '0;
            depth_reg <= '0;
            slot_reg <= '0;
            mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            stk_acc_reg <= stk_acc_next;
            sqr_acc_reg <= sqr_acc_next;
            depth_reg <= depth_next;
            slot_reg <= slot_next;
            mval_reg <= mval_next;
        end
        newest_reg <= newest_next;  nslot_reg <= nslot_next;  jslot_reg <= jslot_next;
        lsamp_reg <= lsamp_next;    last_reg <= last_next;    coh_reg <= coh_next;
        cnt_reg <= cnt_next;        o_reg <= o_next;          oend_reg <= oend_next;
        j_reg <= j_next;            inr_reg <= inr_next;      num_reg <= num_next;
        sq_reg <= sq_next;          kp_reg <= kp_next;        k_reg <= k_next;
        den_reg <= den_next;        div_reg <= div_next;      rem_reg <= rem_next;
        dvd_reg <= dvd_next;        q_reg <= q_next;          semb_reg <= semb_next;
        steps_reg <= steps_next;    wph_reg <= wph_next;      mlast_reg <= mlast_next;
        mdata_reg <= mdata_next;
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        stk_acc_next = stk_acc_reg;  sqr_acc_next = sqr_acc_reg;
        depth_next = depth_reg;      slot_next = slot_reg;
        newest_next = newest_reg;    nslot_next = nslot_reg;   jslot_next = jslot_reg;
        lsamp_next = lsamp_reg;      last_next = last_reg;     coh_next = coh_reg;
        cnt_next = cnt_reg;          o_next = o_reg;           oend_next = oend_reg;
        j_next = j_reg;              inr_next = inr_reg;       num_next = num_reg;
        sq_next = sq_reg;            kp_next = kp_reg;         k_next = k_reg;
        den_next = den_reg;          div_next = div_reg;       rem_next = rem_reg;
        dvd_next = dvd_reg;          q_next = q_reg;           semb_next = semb_reg;
        steps_next = steps_reg;      wph_next = wph_reg;
        mval_next = mval_reg;        mlast_next = mlast_reg;   mdata_next = mdata_reg;

        if (mval_reg && m_tready) mval_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    stk_acc_next = stk_acc_reg + ACC_W'($signed(s_tdata[SAMPLE_WIDTH-1:0]));
                    sqr_acc_next = sqr_acc_reg + ACC_W'(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);
                    lsamp_next = s_tuser;
                    if (s_tlast) state_next = ST_SQUARE;
                end
            end
            // line write, then pick the results this depth releases
            ST_SQUARE: begin
                stk_acc_next = '0;
                sqr_acc_next = '0;
                newest_next = depth_reg;
                nslot_next = slot_reg;
                last_next = lsamp_reg;
                coh_next = coh_eff;
                oend_next = lsamp_reg ? depth_reg : first[DEP_W-1:0];
                o_next = (first < 0) ? '0 : first[DEP_W-1:0];
                if (lsamp_reg || first >= 0) state_next = ST_WIN_SETUP;
                else state_next = ST_IDLE;
                if (lsamp_reg) begin
                    depth_next = '0;
                    slot_next = '0;
                end else begin
                    // past the top, count on in the upper half: index bits and
                    // window bounds stay valid in long gathers
                    depth_next = (depth_reg == DEP_W'(2 * MAX_DEPTH - 1)) ? DEP_W'(MAX_DEPTH)
                               : depth_reg + DEP_W'(1);
                    slot_next = (slot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                              : slot_reg + SLOT_W'(1);
                end
            end
            ST_WIN_SETUP: begin
                j_next = $signed(J_W'(o_reg)) - $signed(J_W'(h_cur));
                jslot_next = js_tmp[SLOT_W] ? SLOT_W'(js_tmp + (SLOT_W+1)'(MAX_WINDOW))
                                            : js_tmp[SLOT_W-1:0];
                cnt_next = coh_reg;
                num_next = '0;
                sq_next = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                inr_next = (j_reg >= 0) && (j_reg <= $signed(J_W'(newest_reg)));
                state_next = ST_ACC;
            end
            // window sum, one entry per read
            ST_ACC: begin
                if (inr_reg) begin
                    num_next = num_reg + NUM_W'(rd_data_reg[SQS_W-1:0]);
                    sq_next = sq_reg + SQ_W'(rd_data_reg[MEM_W-1:SQS_W]);
                end
                j_next = j_reg + J_W'(1);
                jslot_next = (jslot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                           : jslot_reg + SLOT_W'(1);
                cnt_next = cnt_reg - CW'(1);
                state_next = (cnt_reg == CW'(1)) ? ST_KMUL1 : ST_RD;
            end
            ST_KMUL1: begin
                kp_next = (TC_W+SC_W)'(tc_eff) * (TC_W+SC_W)'(sc_eff);
                state_next = ST_KMUL2;
            end
            ST_KMUL2: begin
                k_next = K_W'(kp_reg) * K_W'(dw_eff);
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                den_next = DEN_W'(k_reg) * DEN_W'(sq_reg[HALF_W-1:0]);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                den_next = den_reg + ((DEN_W'(k_reg) * DEN_W'(sq_reg[SQ_W-1:HALF_W])) << HALF_W);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sq_reg == '0) begin
                    semb_next = '0;
                    state_next = ST_WEIGH;
                end else if (CMP_W'(num_reg) >= CMP_W'(den_reg)) begin
                    semb_next = Q_ONE;
                    state_next = ST_WEIGH;
                end else begin
                    rem_next = CMP_W'(num_reg);
                    dvd_next = '0;
                    div_next = den_reg;
                    q_next = '0;
                    steps_next = 6'd16;
                    wph_next = 1'b0;
                    state_next = ST_DIV;
                end
            end
            // restoring division, one quotient bit per cycle
            ST_DIV: begin
                if (rem_sh >= CMP_W'(div_reg)) begin
                    rem_next = rem_sh - CMP_W'(div_reg);
                    q_next = {q_reg[SEMB_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    q_next = {q_reg[SEMB_W-2:0], 1'b0};
                end
                dvd_next = dvd_reg << 1;
                steps_next = steps_reg - 6'd1;
                if (steps_reg == 6'd1) begin
                    semb_next = q_next;
                    state_next = wph_reg ? ST_OUT : ST_WEIGH;
                end
            end
            // threshold ramp
            ST_WEIGH: begin
                state_next = ST_OUT;
                if (wen_reg) begin
                    if (sv > hi_x) semb_next = Q_ONE;
                    else if (sv < lo_x || ds <= 0) semb_next = '0;
                    else begin
                        rem_next = '0;
                        dvd_next = {vd[THR_W-1:0], 16'h0000};
                        div_next = DEN_W'(ds[THR_W-1:0]);
                        q_next = '0;
                        steps_next = 6'(DVD_W);
                        wph_next = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_OUT: begin
                if (!mval_reg || m_tready) begin
                    mval_next = 1'b1;
                    mdata_next = OUT_W'({o_reg[IDX_W-1:0], semb_reg});
                    mlast_next = last_reg && (o_reg == oend_reg);
                    if (o_reg == oend_reg) state_next = ST_IDLE;
                    else begin
                        o_next = o_reg + DEP_W'(1);
                        state_next = ST_WIN_SETUP;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    // checks
    `WSW_ASSERT_IMP(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, div_reg != '0)
    `WSW_ASSERT_NXT(a_close_to_square, aclk, aresetn, s_acc && s_tlast, state_reg == ST_SQUARE)
    `WSW_ASSERT_IMP(a_semb_range, aclk, aresetn, mval_reg, mdata_reg[SEMB_W-1:0] <= Q_ONE)
endmodule

>>> tb/sv/wsw_checker.sv
// Result checker for the windowed semblance core: watches all three channels.
// Keeps its own copy of the registers and line state, predicts every depth
// result and compares it. Depends on wsw_pkg.
`timescale 1ns / 1ps
module wsw_checker
    import wsw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]  cfg_data,
    output int          errors,
    output int          pending,
    output int          results_seen
);
    typedef struct packed {
        logic [16:0] semblance;
        logic [11:0] depth;
        logic        last;
    } depth_result_t;

    depth_result_t pending_depths[$];

    // register copy
    logic [TC_W-1:0] trace_cnt;
    logic [SC_W-1:0] scatter_cnt;
    logic [DW_W-1:0] dip_cnt;
    logic [WL_W-1:0] win_len;
    logic            weight_on;
    longint          thr_low, thr_high;

    // per-depth sums and the depth lines
    logic [27:0] stack_sum, square_sum;
    logic [55:0] sq_stack_line [64];
    logic [27:0] sq_sum_line [64];
    int          depth_ctr;

    function automatic longint at_least_one(longint v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic logic [16:0] ratio_q16(logic [63:0] num, logic [63:0] sq);
        logic [63:0] k, den, rem;
        logic [16:0] q;
        k = at_least_one(trace_cnt) * at_least_one(scatter_cnt) * at_least_one(dip_cnt);
        den = k * sq;
        rem = num;
        q = '0;
        if (sq == 0) return '0;
        if (num >= den) return Q_ONE;
        for (int b = 0; b < 16; b++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [16:0] apply_weight(logic [16:0] s);
        longint v, ds;
        v = s;
        if (!weight_on) return s;
        if (v > thr_high) return Q_ONE;
        if (v < thr_low) return '0;
        ds = thr_high - thr_low;
        if (ds <= 0) return '0;
        return 17'(((v - thr_low) * 65536) / ds);
    endfunction

    // window sum for depth o, queued as the next expected result
    task automatic push_depth(int o, int newest, int coh, int h, bit last);
        logic [63:0] ts, tq;
        depth_result_t r;
        ts = '0;
        tq = '0;
        for (int j = o - h; j < o - h + coh; j++) begin
            if (j >= 0 && j <= newest) begin
                ts += sq_stack_line[j % 64];
                tq += sq_sum_line[j % 64];
            end
        end
        r.semblance = apply_weight(ratio_q16(ts, tq));
        r.depth = 12'(o % 4096);
        r.last = last;
        pending_depths.push_back(r);
    endtask

    task automatic take_trace(logic [23:0] sv, logic [23:0] sq, bit lt, bit ls);
        longint s, mag;
        int newest, coh, h, a, first;
        stack_sum = stack_sum + {{4{sv[23]}}, sv};
        square_sum = square_sum + {4'b0, sq};
        if (!lt) return;
        s = longint'($signed(stack_sum));
        mag = (s < 0) ? -s : s;
        sq_stack_line[depth_ctr % 64] = 56'(mag * mag);
        sq_sum_line[depth_ctr % 64] = square_sum;
        stack_sum = '0;
        square_sum = '0;
        newest = depth_ctr;
        coh = int'(at_least_one(win_len));
        if (coh > 63) coh = 63;
        h = coh / 2;
        a = coh - 1 - h;
        first = newest - a;
        if (ls) begin
            if (first < 0) first = 0;
            for (int o = first; o <= newest; o++) push_depth(o, newest, coh, h, o == newest);
            depth_ctr = 0;
        end else begin
            if (first >= 0) push_depth(first, newest, coh, h, 1'b0);
            depth_ctr++;
        end
    endtask

    always @(posedge aclk) begin
        depth_result_t exp_r;
        if (!aresetn) begin
            trace_cnt <= 1; scatter_cnt <= 1; dip_cnt <= 11; win_len <= 11;
            weight_on <= 0; thr_low <= -65536; thr_high <= -65536;
            stack_sum = '0;
            square_sum = '0;
            depth_ctr = 0;
            for (int i = 0; i < 64; i++) begin
                sq_stack_line[i] = '0;
                sq_sum_line[i] = '0;
            end
            pending_depths.delete();
            errors = 0;
            results_seen = 0;
        end else begin
            // result transaction: compare with the oldest prediction
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (pending_depths.size() == 0) begin
                    $error("unexpected result transaction, tdata %h", m_tdata);
                    errors++;
                end else begin
                    exp_r = pending_depths.pop_front();
                    if (m_tdata[16:0] !== exp_r.semblance) begin
                        $error("semblance expected %0d got %0d", exp_r.semblance, m_tdata[16:0]);
                        errors++;
                    end
                    if (m_tdata[28:17] !== exp_r.depth) begin
                        $error("depth_index expected %0d got %0d", exp_r.depth, m_tdata[28:17]);
                        errors++;
                    end
                    if (m_tlast !== exp_r.last) begin
                        $error("last_output expected %0d got %0d", exp_r.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_trace(s_tdata[23:0], s_tdata[47:24], s_tlast, s_tuser);
            // register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_TRACE_COUNT: trace_cnt   <= cfg_data[TC_W-1:0];
                    CFG_SCATTER:     scatter_cnt <= cfg_data[SC_W-1:0];
                    CFG_DIP_WINDOW:  dip_cnt     <= cfg_data[DW_W-1:0];
                    CFG_WINDOW_LEN:  win_len     <= cfg_data[WL_W-1:0];
                    CFG_WEIGHT_EN:   weight_on   <= cfg_data[0];
                    CFG_WEIGHT_LOW:  thr_low     <= longint'($signed(cfg_data));
                    CFG_WEIGHT_HIGH: thr_high    <= longint'($signed(cfg_data));
                    default: ;
                endcase
            end
        end
        pending = pending_depths.size();
    end
endmodule

>>> tb/sv/windowed_semblance_with_weighting_core_tb.sv
// Top of the windowed semblance testbench: clock, reset, stimulus and verdict.
// Depends on wsw_pkg, wsw_checker and the core itself.
`timescale 1ns / 1ps
module windowed_semblance_with_weighting_core_tb
    import wsw_pkg::*;
();

    localparam int QUIET_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 50000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // [23:0] stack_value, [47:24] square_value
    logic        s_tlast = 0;    // last_trace
    logic        s_tuser = 0;    // last_sample
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;        // [16:0] semblance, [28:17] depth_index, pad
    logic        m_tlast;        // last_output
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [THR_W-1:0]  cfg_data = '0;

    int errors, pending, results_seen;
    int traces_sent = 0, random_traces = 0, gathers = 0;
    bit random_phase = 0;
    bit gaps_on = 1;
    int idle_cycles = 0;
    int cur_traces = 1;

    always #5 aclk = ~aclk;

    windowed_semblance_with_weighting_core i_dut (.*);

    wsw_checker i_checker (.*);

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side: random stalls between result transactions
    initial begin
        int gap;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = gaps_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    task automatic send_trace(logic [23:0] sv, logic [23:0] sq, bit lt, bit ls);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {sq, sv};
        s_tlast <= lt;
        s_tuser <= ls;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        traces_sent++;
        if (random_phase) random_traces++;
        @(negedge aclk);
    endtask

    // drain: sender holds off until every predicted result has arrived
    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_index <= idx;
        cfg_data <= THR_W'(value);
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        if (idx == CFG_TRACE_COUNT) cur_traces = (value[4:0] == 0) ? 1 : value[4:0];
    endtask

    task automatic set_all(int tc, int sc, int dw, int wl, int we, int lo, int hi);
        write_reg(CFG_TRACE_COUNT, tc);
        write_reg(CFG_SCATTER, sc);
        write_reg(CFG_DIP_WINDOW, dw);
        write_reg(CFG_WINDOW_LEN, wl);
        write_reg(CFG_WEIGHT_EN, we);
        write_reg(CFG_WEIGHT_LOW, lo);
        write_reg(CFG_WEIGHT_HIGH, hi);
        cfg_valid <= 0;
    endtask

    // random register setting, extremes included now and then
    task automatic random_setting();
        int tc, sc, dw, wl, lo, hi, t;
        tc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 16 : $urandom_range(1, 6);
        sc = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 20);
        dw = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(0, 12);
        wl = ($urandom_range(0, 7) == 0) ? 63 : $urandom_range(0, 9);
        lo = $urandom_range(0, 131072) - 65536;
        hi = $urandom_range(0, 131072) - 65536;
        if ($urandom_range(0, 3) != 0) begin
            lo = $urandom_range(0, 32768);
            hi = lo + $urandom_range(0, 32768);
        end
        if (lo > hi && $urandom_range(0, 1)) begin
            t = lo; lo = hi; hi = t;
        end
        // junk above the field width must be dropped by the core
        tc |= $urandom_range(0, 1) << 10;
        set_all(tc, sc, dw, wl, $urandom_range(0, 1), lo, hi);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_UNUSED, $urandom);
            cfg_valid <= 0;
        end
    endtask

    // stack/square pair: coherent small values mostly, full range otherwise
    task automatic random_trace(int base, bit lt, bit ls);
        logic [23:0] sv, sq;
        int v;
        case ($urandom_range(0, 3))
            0: begin sv = 24'($urandom); sq = 24'($urandom); end
            1: begin v = base + $urandom_range(0, 200) - 100;
                     sv = 24'(v); sq = 24'(v * v); end
            2: begin v = base; sv = 24'(v); sq = 24'(v * v); end
            default: begin v = $urandom_range(0, 8190) - 4095;
                           sv = 24'(v); sq = 24'(v * v + $urandom_range(0, 4096)); end
        endcase
        send_trace(sv, sq, lt, ls);
    endtask

    task automatic random_gather(int depths);
        int base, nt;
        for (int d = 0; d < depths; d++) begin
            base = $urandom_range(0, 8000) - 4000;
            nt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : cur_traces;
            for (int t = 0; t < nt; t++)
                random_trace(base, t == nt - 1, (d == depths - 1) && (t == nt - 1));
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // single-depth gathers: zero denominator, field extremes, start flush
        set_all(1, 1, 1, 1, 0, -65536, -65536);
        send_trace(24'h800000, 24'h000000, 1, 1);
        send_trace(24'h7fffff, 24'hffffff, 1, 1);
        send_trace(24'h000010, 24'h000100, 1, 1);
        drain();

        // 16 traces at full scale: per-depth sums fill the accumulator width; last_sample on an unmarked trace
        set_all(16, 255, 63, 63, 0, -65536, 65536);
        for (int t = 0; t < 16; t++) send_trace(24'h7fffff, 24'hffffff, t == 15, t == 3);
        for (int t = 0; t < 16; t++) send_trace(24'h800000, 24'hffffff, t == 15, t == 15);
        drain();

        // weighting: equal thresholds, then a reversed pair, zero registers
        set_all(0, 0, 0, 0, 1, 65536, 65536);
        send_trace(24'h000100, 24'h010000, 1, 0);
        send_trace(24'h000100, 24'h010000, 1, 1);
        drain();
        set_all(2, 1, 1, 3, 1, 40000, 10000);
        for (int t = 0; t < 6; t++) send_trace(24'h000200, 24'h040000, t % 2, t == 5);
        drain();

        // random gathers, mostly well-formed
        random_phase = 1;
        while (random_traces < 137) begin
            random_setting();
            random_gather($urandom_range(1, 12));
            gathers++;
            drain();
        end
        gaps_on = 1;

        $display("covered %0d trace transactions, %0d results, %0d random gathers",
                 traces_sent, results_seen, gathers);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
